// ===== hdl/sbe_pkg.sv =====
package sbe_pkg;

  localparam int unsigned NumBinsDefault = 512;
  localparam int unsigned RateW  = 18;
  localparam int unsigned BinsW  = 10;
  localparam int unsigned MagW   = 16;
  localparam int unsigned FreqW  = 16;
  localparam int unsigned BandW  = 4;
  localparam int unsigned ValW   = 13;
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 18;
  localparam int unsigned NumBands = 9;
  localparam logic [ValW-1:0] ValueCap = 13'd6144;

  // divider operand widths: dividend covers freq*2*bins and sum*gain
  localparam int unsigned DivW = 40;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRange = 2'd1,
    OpBand  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegSampleRate = 1'b0,
    RegBinsInUse  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StIdxLo,
    StIdxHi,
    StSum,
    StAvg,
    StOut
  } state_e;

  function automatic logic [FreqW-1:0] band_lo_hz(input logic [BandW-1:0] b);
    logic [FreqW-1:0] r;
    r = '0;
    case (b)
      4'd0: r = 16'd20;
      4'd1: r = 16'd60;
      4'd2: r = 16'd120;
      4'd3: r = 16'd250;
      4'd4: r = 16'd500;
      4'd5: r = 16'd1000;
      4'd6: r = 16'd2000;
      4'd7: r = 16'd4000;
      4'd8: r = 16'd8000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [FreqW-1:0] band_hi_hz(input logic [BandW-1:0] b);
    logic [FreqW-1:0] r;
    r = '0;
    case (b)
      4'd0: r = 16'd60;
      4'd1: r = 16'd120;
      4'd2: r = 16'd250;
      4'd3: r = 16'd500;
      4'd4: r = 16'd1000;
      4'd5: r = 16'd2000;
      4'd6: r = 16'd4000;
      4'd7: r = 16'd8000;
      4'd8: r = 16'd12000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // gain in tenths
  function automatic logic [5:0] band_gain(input logic [BandW-1:0] b);
    logic [5:0] r;
    r = '0;
    case (b)
      4'd0: r = 6'd60;
      4'd1: r = 6'd50;
      4'd2: r = 6'd40;
      4'd3: r = 6'd30;
      4'd4: r = 6'd28;
      4'd5: r = 6'd25;
      4'd6: r = 6'd22;
      4'd7: r = 6'd20;
      4'd8: r = 6'd18;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/sbe_div.sv =====
module sbe_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sbe_pkg::DivW-1:0]  dividend_i,
  input  logic [sbe_pkg::DivW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [sbe_pkg::DivW-1:0]  quotient_o
);
  import sbe_pkg::*;

  localparam int unsigned CntW = $clog2(DivW + 1);

  // restoring divider, one quotient bit per cycle
  logic [DivW-1:0] quo_q, quo_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DivW:0]   trial;
  logic [DivW:0]   shifted;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    shifted = {rem_q, quo_q[DivW-1]};
    trial = shifted - {1'b0, dvs_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = CntW'(DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d |-> busy_q) else $error("divider done without work");
  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && dvs_q != '0) |-> rem_q < dvs_q) else $error("remainder out of range");

endmodule

// ===== hdl/spectrum_band_energy.sv =====
// sequence: a write is stored when accepted and leaves the block idle; a query steps through
//   StIdxLo and StIdxHi (one divide each for the bin indices), StSum (bins lo to hi) and StAvg
//   (one divide for the average), then StOut; busy stays high until the result strobe cycle
//   and a new command is taken only while idle; a query rejected at accept goes straight to StOut
// the divides use the shared one-bit-per-cycle divider, the summation the single spectrum read port
// reset is asynchronous active low, spectrum undefined until written; the receiver cannot stall
module spectrum_band_energy #(
  parameter int unsigned NUM_BINS = sbe_pkg::NumBinsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [sbe_pkg::CfgAddrW-1:0]  cfg_index_i,
  input  logic [sbe_pkg::CfgDataW-1:0]  cfg_data_i,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation_i,
  input  logic [8:0]                    bin_index_i,
  input  logic [sbe_pkg::MagW-1:0]      magnitude_i,
  input  logic [sbe_pkg::FreqW-1:0]     freq_low_i,
  input  logic [sbe_pkg::FreqW-1:0]     freq_high_i,
  input  logic [sbe_pkg::BandW-1:0]     band_i,
  // result side
  output logic                          result_valid_o,
  output logic [sbe_pkg::ValW-1:0]      band_value_o,
  output logic                          rejected_o
);
  import sbe_pkg::*;

  localparam int unsigned AddrW = $clog2(NUM_BINS);
  localparam int unsigned CntW  = $clog2(NUM_BINS + 1);
  // sum of up to NUM_BINS 16-bit magnitudes
  localparam int unsigned SumW  = MagW + CntW;

  // configuration registers
  logic [RateW-1:0] rate_q;
  logic [BinsW-1:0] bins_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q     <= RateW'(48000);
      bins_cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegSampleRate: rate_q     <= cfg_data_i[RateW-1:0];
        RegBinsInUse:  bins_cfg_q <= cfg_data_i[BinsW-1:0];
        default: ;
      endcase
    end
  end

  // active bin count, min(bins_in_use, NUM_BINS)
  logic [CntW-1:0] bins_act;
  always_comb begin
    if ({22'd0, bins_cfg_q} < 32'(NUM_BINS)) begin
      bins_act = CntW'(bins_cfg_q);
    end else begin
      bins_act = CntW'(NUM_BINS);
    end
  end

  // spectrum memory, one write and one read per cycle
  logic [MagW-1:0] spec_mem [NUM_BINS];
  logic [MagW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_addr;
  logic            accept;
  logic            wr_en;

  assign accept = start && !busy;
  assign wr_en  = accept && (operation_i == OpWrite) &&
                  ({23'd0, bin_index_i} < 32'(NUM_BINS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      spec_mem[AddrW'(bin_index_i)] <= magnitude_i;
    end
    rd_data_q <= spec_mem[rd_addr];
  end

  // sequencer state
  state_e          state_q, state_d;
  logic [FreqW-1:0] flo_q, fhi_q;
  logic [5:0]      gain_q;
  logic            is_band_q;
  logic [AddrW-1:0] lo_q, hi_q, ptr_q;
  logic            rd_pend_q;
  logic            rd_last_q;  // the read in flight is the last bin of the range
  logic [SumW-1:0] sum_q;
  logic [ValW-1:0] val_q;
  logic            rej_q;
  logic            res_q;

  // divider sharing
  logic            div_start;
  logic [DivW-1:0] div_num, div_den;
  logic            div_done;
  logic [DivW-1:0] div_quo;

  sbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic            div_go_q;   // launch divider in the first cycle of StIdxLo, StIdxHi or StAvg
  logic [AddrW-1:0] clamped;
  logic [AddrW-1:0] last_bin;
  logic [CntW-1:0] count;
  logic [SumW+5:0] scaled;
  logic            query_ok;

  assign last_bin = AddrW'(bins_act - 1'b1);
  assign clamped  = (div_quo > DivW'(last_bin)) ? last_bin : AddrW'(div_quo);
  assign count    = CntW'(hi_q - lo_q) + 1'b1;
  assign scaled   = is_band_q ? (SumW+6)'(sum_q) * gain_q : (SumW+6)'(sum_q);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state_q)
      StIdxLo: begin
        div_num = DivW'(flo_q) * DivW'(bins_act) * DivW'(2);
        div_den = DivW'(rate_q);
      end
      StIdxHi: begin
        div_num = DivW'(fhi_q) * DivW'(bins_act) * DivW'(2);
        div_den = DivW'(rate_q);
      end
      StAvg: begin
        div_num = DivW'(scaled);
        div_den = is_band_q ? DivW'(count) * DivW'(10) : DivW'(count);
      end
      default: ;
    endcase
  end
  assign div_start = div_go_q;

  // validity of a query at acceptance
  always_comb begin
    query_ok = (rate_q != '0) && (bins_act != '0);
    if (operation_i == OpRange) begin
      query_ok = query_ok && (freq_low_i != '0) && (freq_high_i != '0) &&
                 (freq_low_i < freq_high_i);
    end else begin
      query_ok = query_ok && (band_i < BandW'(NumBands));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (operation_i == OpRange || operation_i == OpBand) begin
            state_d = query_ok ? StIdxLo : StOut;
          end
        end
      end
      StIdxLo: if (div_done) state_d = StIdxHi;
      StIdxHi: if (div_done) state_d = (lo_q > clamped) ? StOut : StSum;
      StSum:   if (rd_last_q) state_d = StAvg;
      StAvg:   if (div_done) state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign rd_addr = ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      div_go_q  <= 1'b0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
      res_q     <= 1'b0;
      rej_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_d != state_q) &&
                  (state_d == StIdxLo || state_d == StIdxHi || state_d == StAvg);
      res_q    <= (state_q == StOut);
      if (state_q == StIdle && accept) begin
        rej_q <= !query_ok;
      end else if (state_q == StIdxHi && div_done && lo_q > clamped) begin
        rej_q <= 1'b1;
      end
      // memory read issued from ptr, data registered and valid in the next cycle
      rd_pend_q <= (state_q == StSum) && !rd_last_q;
      rd_last_q <= (state_q == StSum) && !rd_last_q && (ptr_q == hi_q);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && accept) begin
      is_band_q <= (operation_i == OpBand);
      if (operation_i == OpRange) begin
        flo_q <= freq_low_i;
        fhi_q <= freq_high_i;
      end else begin
        flo_q <= band_lo_hz(band_i);
        fhi_q <= band_hi_hz(band_i);
      end
      gain_q <= band_gain(band_i);
      val_q  <= '0;
    end
    if (state_q == StIdxLo && div_done) lo_q <= clamped;
    if (state_q == StIdxHi && div_done) begin
      hi_q  <= clamped;
      ptr_q <= lo_q;
      sum_q <= '0;
    end
    if (state_q == StSum) begin
      if (rd_pend_q) sum_q <= sum_q + SumW'(rd_data_q);
      if (!rd_last_q && ptr_q != hi_q) ptr_q <= ptr_q + 1'b1;
    end
    if (state_q == StAvg && div_done) begin
      val_q <= (div_quo > DivW'(ValueCap)) ? ValueCap : ValW'(div_quo);
    end
    if (state_q == StIdxHi && div_done && lo_q > clamped) val_q <= '0;
  end

  // outputs
  assign busy           = (state_q != StIdle);
  assign result_valid_o = res_q;
  assign band_value_o   = rej_q ? '0 : val_q;
  assign rejected_o     = rej_q;

  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |=> !res_q) else $error("result strobe held");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> band_value_o <= ValueCap) else $error("result above cap");
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> state_q == StIdle) else $error("result outside idle");
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OpWrite) |=> !busy) else $error("write left block busy");

endmodule
